### sv/lega_pkg.sv
// Package for the Laplacian edge grid accumulator: request codes, defaults,
// the gray conversion function and the sequencer state type. No dependencies.
package lega_pkg;
  localparam int LineMaxDef  = 4096;
  localparam int GridMaxWDef = 64;
  localparam int GridMaxHDef = 64;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GRID_W = 2'd2;
  localparam logic [1:0] REG_GRID_H = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PIX_RD, ST_PIX_DIV, ST_PIX_ACC, ST_PIX_WR, ST_READ
  } state_t;

  function automatic logic [7:0] to_gray(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [24:0] s;
    s = 25'(17'd13933 * r) + 25'(17'd46871 * g) + 25'(17'd4732 * b) + 25'd32768;
    return s[23:16];
  endfunction
endpackage

### sv/lega_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on lega_pkg.
module lega_divider import lega_pkg::*; #(
  parameter int NumW = 24,
  parameter int DenW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            busy,
  output logic [NumW-1:0] quo
);
  localparam int CntW = $clog2(NumW + 1);
  logic [DenW:0]   rem;
  logic [NumW-1:0] sh;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic [DenW:0]   trial;

  assign trial = {rem[DenW-1:0], sh[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(NumW);
      rem  <= '0;
      sh   <= num;
      d    <= den;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        quo <= {quo[NumW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NumW-2:0], 1'b0};
      end
      sh  <= sh << 1;
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end
endmodule

### sv/lega_line_store.sv
// Two-bank gray line store, one synchronous memory with registered read.
// Depends on lega_pkg.
module lega_line_store import lega_pkg::*; #(
  parameter int AW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/lega_grid_mem.sv
// Grid accumulator memory, 15-bit cells, synchronous read.
// Depends on lega_pkg.
module lega_grid_mem import lega_pkg::*; #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [14:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [14:0]   rdata
);
  logic [14:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/laplacian_edge_grid_accumulator_unit.sv
// Top level of the Laplacian edge grid accumulator.
// Depends on lega_pkg, lega_line_store, lega_grid_mem, lega_divider.
//
//  channel  | handshake                | word
//  ---------+--------------------------+-------------------------------------
//  in       | in_valid / in_ready      | req_type, red, green, blue, cell_*
//  out      | out_valid / out_ready    | cell_value
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One word at a time. A start word walks the grid, one cell a cycle
// (2**cell-address-bits cells, 4096 at the defaults); reset does the same walk
// before in_ready. An interior pixel holds the input through its line-store
// reads and two 25-step cell-index divisions sharing one serial divider; an
// edge pixel only stores its gray value, and a pixel beyond the last row is dropped.
// Interior line-store reads are four, one per cycle, through the single read port.
// A read result waits in the output register; a following read stalls until it leaves.
module laplacian_edge_grid_accumulator_unit import lega_pkg::*; #(
  parameter int LINE_MAX   = LineMaxDef,
  parameter int GRID_MAX_W = GridMaxWDef,
  parameter int GRID_MAX_H = GridMaxHDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [5:0]  cell_col,
  input  logic [5:0]  cell_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] cell_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int LW  = $clog2(LINE_MAX);
  localparam int GXW = (GRID_MAX_W > 1) ? $clog2(GRID_MAX_W) : 1;
  localparam int GYW = (GRID_MAX_H > 1) ? $clog2(GRID_MAX_H) : 1;
  localparam int GAW = GXW + GYW;
  localparam int NUMW = 16 + 9;
  localparam int CLRN = 2 ** GAW;

  logic [12:0] image_width;
  logic [15:0] image_height;
  logic [6:0]  grid_width, grid_height;

  // effective sizes
  logic [16:0] w_eff;
  logic [15:0] h_eff;
  logic [8:0]  gw_eff, gh_eff;
  always_comb begin
    w_eff = (image_width == 13'd0) ? 17'd1 :
            (17'(image_width) > 17'(LINE_MAX)) ? 17'(LINE_MAX) : 17'(image_width);
    h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
    gw_eff = (grid_width == 7'd0) ? 9'd1 :
             (9'(grid_width) > 9'(GRID_MAX_W)) ? 9'(GRID_MAX_W) : 9'(grid_width);
    gh_eff = (grid_height == 7'd0) ? 9'd1 :
             (9'(grid_height) > 9'(GRID_MAX_H)) ? 9'(GRID_MAX_H) : 9'(grid_height);
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd640;
      image_height <= 16'd480;
      grid_width   <= 7'd64;
      grid_height  <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[12:0];
        REG_HEIGHT: image_height <= cfg_data;
        REG_GRID_W: grid_width   <= cfg_data[6:0];
        REG_GRID_H: grid_height  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [16:0] col, row;          // position counters
  logic [16:0] x, r;              // position of current pixel
  logic [7:0]  gray;
  logic [1:0]  rd_step;
  logic [7:0]  g_up, g_left, g_right;
  logic [9:0]  c4;
  logic [14:0] diff;
  logic        interior;
  logic [GAW:0] clr_cnt;
  logic [1:0]  div_phase;
  logic [GXW-1:0] gx;
  logic [GYW-1:0] gy;
  logic [GAW-1:0] rd_addr;        // cell of the pending read
  logic        rd_oob;            // read beyond the maximum grid, answers zero
  logic        skip;
  logic [16:0] col_n, row_n;
  logic        out_free;

  // line store
  logic          ls_we;
  logic [LW:0]   ls_waddr, ls_raddr;
  logic [7:0]    ls_rdata;
  lega_line_store #(.AW(LW + 1)) u_line (
    .clk, .we(ls_we), .waddr(ls_waddr), .wdata(gray),
    .raddr(ls_raddr), .rdata(ls_rdata)
  );

  // grid memory
  logic           gm_we;
  logic [GAW-1:0] gm_waddr, gm_raddr;
  logic [14:0]    gm_wdata, gm_rdata;
  lega_grid_mem #(.AW(GAW)) u_grid (
    .clk, .we(gm_we), .waddr(gm_waddr), .wdata(gm_wdata),
    .raddr(gm_raddr), .rdata(gm_rdata)
  );

  // divider shared by the two cell indices
  logic            dv_start, dv_busy;
  logic [NUMW-1:0] dv_num, dv_quo;
  logic [16:0]     dv_den;
  lega_divider #(.NumW(NUMW), .DenW(17)) u_div (
    .clk, .rst, .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .quo(dv_quo)
  );

  logic in_acc;
  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // row banks: centre row r-1
  logic [LW:0] a_cl, a_cr, a_cc;
  always_comb begin
    a_cl = {~r[0], LW'(x - 17'd1)};
    a_cr = {~r[0], LW'(x + 17'd1)};
    a_cc = {~r[0], x[LW-1:0]};
  end
  // r-2 and r have same parity as a bank: up row lives in bank r[0]
  logic [LW:0] a_upb;
  assign a_upb = {r[0], x[LW-1:0]};

  always_comb begin
    state_next = state;
    ls_raddr   = a_upb;
    unique case (rd_step)
      2'd0: ls_raddr = a_upb;
      2'd1: ls_raddr = a_cl;
      2'd2: ls_raddr = a_cr;
      default: ls_raddr = a_cc;
    endcase
    gm_raddr = {GYW'(cell_row), GXW'(cell_col)};
    if (state == ST_READ) gm_raddr = rd_addr;
    else if (state != ST_IDLE) gm_raddr = {gy, gx};
    unique case (state)
      ST_CLEAR:   if (clr_cnt == (GAW+1)'(CLRN - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (req_type)
            REQ_START: state_next = ST_CLEAR;
            REQ_PIXEL: state_next = skip ? ST_IDLE : ST_PIX_RD;
            REQ_READ:  state_next = ST_READ;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD:  if (!interior) state_next = ST_PIX_WR;
                  else if (rd_step == 2'd3) state_next = ST_PIX_DIV;
      ST_PIX_DIV: if (div_phase == 2'd3) state_next = ST_PIX_ACC;
      ST_PIX_ACC: state_next = ST_PIX_WR;
      ST_PIX_WR:  state_next = ST_IDLE;
      ST_READ:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // a row that ran past a lowered width is closed before the pixel is placed
  always_comb begin
    col_n = col; row_n = row; skip = 1'b0;
    if (row >= 17'(h_eff)) skip = 1'b1;
    else if (col >= w_eff) begin
      col_n = '0; row_n = row + 17'd1;
      if (row_n >= 17'(h_eff)) skip = 1'b1;
    end
  end

  logic [10:0] sum;
  assign sum = 11'(g_up) + 11'(gray) + 11'(g_left) + 11'(g_right);

  logic [15:0] acc_sum;
  assign acc_sum = 16'(gm_rdata) + 16'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
      rd_step   <= '0;
      div_phase <= '0;
    end else begin
      state <= state_next;
      if (state == ST_READ && out_free) begin
        out_valid  <= 1'b1;
        cell_value <= rd_oob ? 15'd0 : gm_rdata;
      end else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          rd_step <= '0; div_phase <= '0;
          if (in_acc && req_type == REQ_START) begin
            clr_cnt <= '0; col <= '0; row <= '0;
          end
          if (in_acc && req_type == REQ_PIXEL) begin
            gray <= to_gray(red, green, blue);
            col <= col_n; row <= row_n;
            x <= col_n; r <= row_n;
          end
          if (in_acc && req_type == REQ_READ) begin
            rd_addr <= {GYW'(cell_row), GXW'(cell_col)};
            rd_oob  <= (9'(cell_col) >= 9'(GRID_MAX_W)) || (9'(cell_row) >= 9'(GRID_MAX_H));
          end
        end
        ST_PIX_RD: begin
          rd_step <= rd_step + 1'b1;
          unique case (rd_step)
            2'd1: g_up    <= ls_rdata;
            2'd2: g_left  <= ls_rdata;
            2'd3: g_right <= ls_rdata;
            default: ;
          endcase
        end
        ST_PIX_DIV: begin
          unique case (div_phase)
            2'd0: begin
              c4 <= {ls_rdata, 2'b00};
              div_phase <= 2'd1;
            end
            2'd1: if (!dv_busy) begin
              gx <= GXW'(dv_quo);
              div_phase <= 2'd2;
            end
            2'd2: if (!dv_busy) begin
              gy <= GYW'(dv_quo);
              div_phase <= 2'd3;
            end
            default: ;
          endcase
          diff <= 15'((11'({1'b0, c4}) > sum) ? 11'({1'b0, c4}) - sum : sum - 11'({1'b0, c4}));
        end
        ST_PIX_ACC: ;
        ST_PIX_WR: begin
          if (col + 17'd1 >= w_eff) begin
            col <= '0; row <= row + 17'd1;
          end else col <= col + 17'd1;
        end
        default: ;
      endcase
    end
  end

  // divider launches: x*gw/w at phase 0, (r-1)*gh/h once the first is done
  always_comb begin
    dv_start = 1'b0;
    dv_num   = NUMW'(x[15:0]) * NUMW'(gw_eff);
    dv_den   = w_eff;
    if (state == ST_PIX_DIV && div_phase == 2'd0) dv_start = 1'b1;
    if (state == ST_PIX_DIV && div_phase == 2'd1) begin
      dv_start = !dv_busy;
      dv_num   = NUMW'(r[15:0] - 16'd1) * NUMW'(gh_eff);
      dv_den   = 17'(h_eff);
    end
  end

  assign interior = (r >= 17'd2) && (x >= 17'd1) && (x + 17'd2 <= w_eff);

  always_comb begin
    gm_we    = 1'b0;
    gm_waddr = {gy, gx};
    gm_wdata = (acc_sum > 16'd32767) ? 15'h7FFF : acc_sum[14:0];
    if (state == ST_CLEAR) begin
      gm_we = 1'b1; gm_waddr = clr_cnt[GAW-1:0]; gm_wdata = '0;
    end else if (state == ST_PIX_ACC) gm_we = 1'b1;
    ls_we    = (state == ST_PIX_WR);
    ls_waddr = {r[0], x[LW-1:0]};
  end

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready) else $error("input taken during clear");
  a_out_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> out_valid) else $error("read gave no result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_value))
    else $error("result word dropped while stalled");
`endif
endmodule
